// ===== sv/mck_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, register indexes and arithmetic helpers for the mecanum
// chassis kinematics unit.
// ----------------------------------------------------------------------------
package mck_pkg;

  // fixed-point formats of the geometry registers
  localparam int GEOM_FRAC  = 16;
  localparam int RECIP_FRAC = 24;

  // register defaults after reset
  localparam logic        LAYOUT_RST     = 1'b0;
  localparam logic [23:0] GEOM_SUM_RST   = 24'd19661;
  localparam logic [31:0] GEOM_RECIP_RST = 32'd13981013;

  // internal widths
  localparam int SUM_W  = 34;  // exact sum of four 32-bit speeds
  localparam int PP_W   = 50;  // 34 x 16 partial product
  localparam int FULL_W = 67;  // recombined product plus rounding carry
  localparam int Q_W    = 42;  // scaled magnitude
  localparam int K_W    = 43;  // signed scaled term
  localparam int RES_W  = 45;  // pre-saturation result

  localparam logic signed [RES_W-1:0] S32_MAX = 45'sd2147483647;
  localparam logic signed [RES_W-1:0] S32_MIN = -45'sd2147483648;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LAYOUT     = 2'd0,
    CFG_GEOM_SUM   = 2'd1,
    CFG_GEOM_RECIP = 2'd2
  } cfg_idx_t;

  // wheel arrangement
  localparam logic LAYOUT_O = 1'b0;
  localparam logic LAYOUT_X = 1'b1;

  // conversion direction
  localparam logic FUNC_INVERSE = 1'b0;
  localparam logic FUNC_FORWARD = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_w;
    logic signed [31:0] wheel_in0;
    logic signed [31:0] wheel_in1;
    logic signed [31:0] wheel_in2;
    logic signed [31:0] wheel_in3;
  } kin_in_t;

  typedef struct packed {
    logic signed [31:0] wheel_out0;
    logic signed [31:0] wheel_out1;
    logic signed [31:0] wheel_out2;
    logic signed [31:0] wheel_out3;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
    logic signed [31:0] est_w;
    logic               overflow;
  } kin_out_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // clamp to the signed 32-bit range and flag a clamp
  function automatic sat_t sat32(input logic signed [RES_W-1:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > S32_MAX) begin
      s.ovf = 1'b1;
      s.val = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      s.ovf = 1'b1;
      s.val = S32_MIN[31:0];
    end
    return s;
  endfunction

  // divide by four, round to nearest with halves away from zero
  function automatic logic signed [RES_W-1:0] rnd_div4(input logic signed [SUM_W-1:0] v);
    logic [SUM_W:0]           m;
    logic [SUM_W:0]           q;
    logic signed [RES_W-1:0]  r;
    m = v[SUM_W-1] ? (SUM_W+1)'(-{v[SUM_W-1], v}) : {1'b0, v};
    q = (m + (SUM_W+1)'(2)) >> 2;
    r = {{(RES_W-SUM_W-1){1'b0}}, q};
    return v[SUM_W-1] ? -r : r;
  endfunction

endpackage

// ===== sv/mecanum_chassis_kinematics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_chassis_kinematics_unit
// Four-wheel mecanum kinematics in Q16.16: body velocity to wheel targets
// (inverse) or measured wheel speeds to body estimate (forward), with
// saturation and an overflow flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | kin_in_t  (func, body, wheels)
//  out_    | output    | out_valid/out_stall| kin_out_t (wheels, est, ovf)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One transaction per cycle while out_stall is low: four register
//  stages (operand sums, split multiply, recombine and round, add/saturate).
//  Synchronous active-low reset clears stage valids and restores registers.
//  out_stall freezes the last full stage; upstream stages keep filling bubbles
//  and in_stall rises only when every stage holds a transaction.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module mecanum_chassis_kinematics_unit
  import mck_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  kin_in_t        in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output kin_out_t       out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  // configuration registers
  logic        layout_r;
  logic [23:0] geom_sum_r;
  logic [31:0] geom_recip_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r     <= LAYOUT_RST;
      geom_sum_r   <= GEOM_SUM_RST;
      geom_recip_r <= GEOM_RECIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAYOUT:     layout_r     <= cfg_data[0];
        CFG_GEOM_SUM:   geom_sum_r   <= cfg_data[23:0];
        CFG_GEOM_RECIP: geom_recip_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables, a stage loads when empty or when its successor drains it
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_valid;
      if (en2) v2_r        <= v1_r;
      if (en3) v3_r        <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- stage 1: signed sums and multiplier operand ------------
  logic signed [SUM_W-1:0] vx, vy, w, v0, v1, v2, v3;
  logic signed [SUM_W-1:0] inv_a, inv_b, fwd_all, fwd_alt, fwd_dif, fwd_x, fwd_y, fwd_s;
  logic signed [SUM_W-1:0] opnd;
  logic                    s1_func_nxt, s1_neg_nxt;
  logic signed [SUM_W-1:0] s1_sum_a_nxt, s1_sum_b_nxt;
  logic [SUM_W-1:0]        s1_mag_nxt;
  logic [31:0]             s1_coef_nxt;

  logic                    s1_func_r, s1_neg_r;
  logic signed [SUM_W-1:0] s1_sum_a_r, s1_sum_b_r;
  logic [SUM_W-1:0]        s1_mag_r;
  logic [31:0]             s1_coef_r;

  always_comb begin
    vx = SUM_W'(in_data.body_vx);
    vy = SUM_W'(in_data.body_vy);
    w  = SUM_W'(in_data.body_w);
    v0 = SUM_W'(in_data.wheel_in0);
    v1 = SUM_W'(in_data.wheel_in1);
    v2 = SUM_W'(in_data.wheel_in2);
    v3 = SUM_W'(in_data.wheel_in3);

    // inverse base terms
    if (layout_r == LAYOUT_X) begin
      inv_a = vx + vy;
      inv_b = vx - vy;
    end else begin
      inv_a = vy - vx;
      inv_b = vy + vx;
    end

    // forward sums
    fwd_all = v0 + v1 + v2 + v3;
    fwd_alt = v0 - v1 + v2 - v3;
    fwd_dif = v1 - v0 + v3 - v2;
    fwd_s   = v0 - v1 - v2 + v3;
    if (layout_r == LAYOUT_X) begin
      fwd_x = fwd_all;
      fwd_y = fwd_alt;
    end else begin
      fwd_x = fwd_dif;
      fwd_y = fwd_all;
    end

    s1_func_nxt = in_data.func;
    if (in_data.func == FUNC_FORWARD) begin
      s1_sum_a_nxt = fwd_x;
      s1_sum_b_nxt = fwd_y;
      opnd         = fwd_s;
      s1_coef_nxt  = geom_recip_r;
    end else begin
      s1_sum_a_nxt = inv_a;
      s1_sum_b_nxt = inv_b;
      opnd         = w;
      s1_coef_nxt  = {8'b0, geom_sum_r};
    end

    // sign and magnitude of the scaled operand
    s1_neg_nxt = opnd[SUM_W-1];
    s1_mag_nxt = s1_neg_nxt ? SUM_W'(-opnd) : SUM_W'(opnd);
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_func_r  <= s1_func_nxt;
      s1_neg_r   <= s1_neg_nxt;
      s1_sum_a_r <= s1_sum_a_nxt;
      s1_sum_b_r <= s1_sum_b_nxt;
      s1_mag_r   <= s1_mag_nxt;
      s1_coef_r  <= s1_coef_nxt;
    end
  end

  // ---------------- stage 2: split multiply, two 34 x 16 products ----------
  logic [PP_W-1:0]         s2_plo_nxt, s2_phi_nxt;
  logic [PP_W-1:0]         s2_plo_r, s2_phi_r;
  logic                    s2_func_r, s2_neg_r;
  logic signed [SUM_W-1:0] s2_sum_a_r, s2_sum_b_r;

  assign s2_plo_nxt = {16'b0, s1_mag_r} * {{(PP_W-16){1'b0}}, s1_coef_r[15:0]};
  assign s2_phi_nxt = {16'b0, s1_mag_r} * {{(PP_W-16){1'b0}}, s1_coef_r[31:16]};

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      s2_plo_r   <= s2_plo_nxt;
      s2_phi_r   <= s2_phi_nxt;
      s2_func_r  <= s1_func_r;
      s2_neg_r   <= s1_neg_r;
      s2_sum_a_r <= s1_sum_a_r;
      s2_sum_b_r <= s1_sum_b_r;
    end
  end

  // ---------------- stage 3: recombine, round and restore sign -------------
  logic [FULL_W-1:0]       full_prod, rnd_sum, shifted;
  logic [Q_W-1:0]          q_mag;
  logic signed [K_W-1:0]   s3_k_nxt;
  logic signed [K_W-1:0]   s3_k_r;
  logic                    s3_func_r;
  logic signed [SUM_W-1:0] s3_sum_a_r, s3_sum_b_r;

  always_comb begin
    full_prod = {1'b0, s2_phi_r, 16'b0} + {{(FULL_W-PP_W){1'b0}}, s2_plo_r};
    if (s2_func_r == FUNC_FORWARD) begin
      rnd_sum = full_prod + (FULL_W'(1) << (RECIP_FRAC - 1));
      shifted = rnd_sum >> RECIP_FRAC;
    end else begin
      rnd_sum = full_prod + (FULL_W'(1) << (GEOM_FRAC - 1));
      shifted = rnd_sum >> GEOM_FRAC;
    end
    q_mag    = shifted[Q_W-1:0];
    s3_k_nxt = s2_neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      s3_k_r     <= s3_k_nxt;
      s3_func_r  <= s2_func_r;
      s3_sum_a_r <= s2_sum_a_r;
      s3_sum_b_r <= s2_sum_b_r;
    end
  end

  // ---------------- stage 4: final sums and saturation ---------------------
  logic signed [RES_W-1:0] a_ext, b_ext, k_ext;
  sat_t      sat0, sat1, sat2, sat3, sat_x, sat_y, sat_w;
  kin_out_t  out_nxt;
  kin_out_t  out_data_r;

  always_comb begin
    a_ext = RES_W'(s3_sum_a_r);
    b_ext = RES_W'(s3_sum_b_r);
    k_ext = RES_W'(s3_k_r);

    sat0  = sat32(a_ext + k_ext);
    sat1  = sat32(b_ext - k_ext);
    sat2  = sat32(a_ext - k_ext);
    sat3  = sat32(b_ext + k_ext);
    sat_x = sat32(rnd_div4(s3_sum_a_r));
    sat_y = sat32(rnd_div4(s3_sum_b_r));
    sat_w = sat32(k_ext);

    out_nxt = '0;
    if (s3_func_r == FUNC_FORWARD) begin
      out_nxt.est_vx   = sat_x.val;
      out_nxt.est_vy   = sat_y.val;
      out_nxt.est_w    = sat_w.val;
      out_nxt.overflow = sat_x.ovf | sat_y.ovf | sat_w.ovf;
    end else begin
      out_nxt.wheel_out0 = sat0.val;
      out_nxt.wheel_out1 = sat1.val;
      out_nxt.wheel_out2 = sat2.val;
      out_nxt.wheel_out3 = sat3.val;
      out_nxt.overflow   = sat0.ovf | sat1.ovf | sat2.ovf | sat3.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== sv/mck_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mck_checker
// Port-level checks for the mecanum chassis kinematics unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module mck_checker
  import mck_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input kin_out_t    out_data
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only one direction's fields are populated
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.est_vx == '0 && out_data.est_vy == '0 && out_data.est_w == '0)
               || (out_data.wheel_out0 == '0 && out_data.wheel_out1 == '0
                   && out_data.wheel_out2 == '0 && out_data.wheel_out3 == '0))
    else $error("both wheel and body fields nonzero");

  // an overflow flag comes with at least one clamped field
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      out_data.wheel_out0 == 32'sh7fffffff || out_data.wheel_out0 == 32'sh80000000 ||
      out_data.wheel_out1 == 32'sh7fffffff || out_data.wheel_out1 == 32'sh80000000 ||
      out_data.wheel_out2 == 32'sh7fffffff || out_data.wheel_out2 == 32'sh80000000 ||
      out_data.wheel_out3 == 32'sh7fffffff || out_data.wheel_out3 == 32'sh80000000 ||
      out_data.est_vx == 32'sh7fffffff || out_data.est_vx == 32'sh80000000 ||
      out_data.est_vy == 32'sh7fffffff || out_data.est_vy == 32'sh80000000 ||
      out_data.est_w == 32'sh7fffffff || out_data.est_w == 32'sh80000000)
    else $error("overflow without a clamped field");

  // an accepted transaction with a free output path shows up after passing through every stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("transaction lost in pipeline");

endmodule

bind mecanum_chassis_kinematics_unit mck_checker u_mck_checker (.*);
